// File: rtl/clre_pkg.sv
// Shared constants and types for the character LCD refresh engine.
// No dependencies; used by the top level, the checker and the testbench.
`default_nettype none

package clre_pkg;

    // Display geometry
    localparam int DISPLAY_CELLS = 80;
    localparam int SEGMENT_SPAN  = 20;
    localparam int ADDR_W        = $clog2(DISPLAY_CELLS);
    localparam int SECOND_BANK   = 40;
    localparam int BANK_REMAP    = 24;

    // Default geometry parameters
    localparam int DEF_LINE_CELLS = 20;
    localparam int DEF_LINES      = 4;

    // Codes
    localparam logic [7:0] CMD_SET_ADDRESS = 8'h80;
    localparam logic [7:0] NEWLINE_CODE    = 8'd10;
    localparam logic [7:0] BLANK_RESET     = 8'd32;
    localparam logic [7:0] ADDR_UNKNOWN    = 8'hFF;

    // Input item kinds
    typedef enum logic [1:0] {
        F_CLEAR  = 2'd0,
        F_PUT    = 2'd1,
        F_SET    = 2'd2,
        F_RENDER = 2'd3
    } t_func;

    // Configuration register indexes
    localparam logic REG_BLANK_CODE = 1'b0;

    // Result of a cell address lookup
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] addr;
    } t_cell_addr;

endpackage

`default_nettype wire

// File: rtl/clre_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module clre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/character_lcd_refresh_engine_core.sv
// Character LCD refresh engine: pending/shown shadow buffers and render sequencer.
// Depends on clre_pkg and clre_ram.
`default_nettype none

// Keeps a pending buffer of display codes and a copy of what the panel shows,
// and on a render item emits only the bytes needed to bring one 20-address
// segment up to date (set-address command where the panel's address counter is
// not already at the cell, then the data byte). Clear, put and set items are
// handled in the idle state; clear re-tags the whole pending buffer at once
// through its per-cell valid bits, so no sweep is needed. A render item walks
// its segment through one compare unit: the scan state passes over unchanged
// cells, a changed cell goes through the command state where an address
// command is needed and then the data state, and a flush state closes the
// transaction run; output stalls can hold the command, data and flush states.
// The input is not ready while a render runs. No clearing pass follows reset.
module character_lcd_refresh_engine_core
    import clre_pkg::*;
#(
    parameter int LINE_CELLS = DEF_LINE_CELLS,
    parameter int LINES      = DEF_LINES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input items
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [4:0] column, [7:5] row, [15:8] code, [17:16] segment, [23:18] zero
    input  wire [23:0]  i_s_axis_tdata,
    // [1:0] func
    input  wire [1:0]   i_s_axis_tuser,
    // Result items
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  o_m_axis_tdata,
    // [0] reg_select
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    // Configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W = $clog2(LINE_CELLS + 1);
    localparam int ROW_W = 3;
    localparam logic [ADDR_W-1:0] SPAN_LAST = ADDR_W'(SEGMENT_SPAN - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMD,
        S_DATA,
        S_FLUSH
    } t_state;

    // Input fields
    t_func       in_func;
    logic [4:0]  in_column;
    logic [2:0]  in_row;
    logic [7:0]  in_code;
    logic [1:0]  in_segment;

    // State
    t_state              r_state;
    logic [7:0]          r_blank;
    logic [7:0]          r_fill;
    logic [DISPLAY_CELLS-1:0] r_pvalid;
    logic [DISPLAY_CELLS-1:0] r_svalid;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [7:0]          r_tracked;
    logic [ADDR_W-1:0]   r_idx;
    logic [ADDR_W-1:0]   r_last_idx;
    logic [7:0]          r_cell;
    logic                r_hold_v;
    logic                r_hold_rs;
    logic [7:0]          r_hold_byte;
    logic                r_out_valid;
    logic                r_out_rs;
    logic [7:0]          r_out_byte;
    logic                r_out_last;

    logic [ADDR_W-1:0]   n_idx;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    n_row;

    logic                in_accept;
    logic                cfg_write;
    logic [7:0]          pend_rdata;
    logic [7:0]          shown_rdata;
    logic [7:0]          pend_val;
    logic [7:0]          shown_val;
    logic                out_free;
    logic                can_push;
    logic                push_req;
    logic                push_rs;
    logic [7:0]          push_byte;
    logic [ADDR_W-1:0]   remap;
    logic [ADDR_W-1:0]   seg_start;
    logic                pwe;
    logic [ADDR_W-1:0]   pwaddr;
    logic                swe;
    logic                at_last;
    t_cell_addr          set_ca;
    t_cell_addr          put_ca;
    logic [COL_W-1:0]    eff_col;
    logic [ROW_W-1:0]    eff_row;
    logic [ROW_W-1:0]    adv_row;

    // Display address of a cell, flagged invalid when outside the panel
    function automatic t_cell_addr cell_address(input logic [7:0] col,
                                                input logic [ROW_W-1:0] row);
        t_cell_addr res;
        logic [7:0] base;
        logic [7:0] sum;
        case (row)
            3'd0:    base = 8'd0;
            3'd1:    base = 8'(SECOND_BANK);
            3'd2:    base = 8'(LINE_CELLS);
            default: base = 8'(SECOND_BANK + LINE_CELLS);
        endcase
        sum      = base + col;
        res.ok   = (col < 8'(LINE_CELLS)) && (row < ROW_W'(LINES))
                   && (sum < 8'(DISPLAY_CELLS));
        res.addr = sum[ADDR_W-1:0];
        return res;
    endfunction

    // Field unpacking
    assign in_func    = t_func'(i_s_axis_tuser);
    assign in_column  = i_s_axis_tdata[4:0];
    assign in_row     = i_s_axis_tdata[7:5];
    assign in_code    = i_s_axis_tdata[15:8];
    assign in_segment = i_s_axis_tdata[17:16];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_BLANK_CODE);
    assign prdata    = (paddr[2] == REG_BLANK_CODE) ? {24'd0, r_blank} : 32'd0;

    // Set cell address
    assign set_ca = cell_address({3'd0, in_column}, in_row);

    // Put: wrap at a full line, then place the character; newline moves to the next line
    assign adv_row = (r_row < ROW_W'(LINES)) ? r_row + ROW_W'(1) : r_row;
    always_comb begin
        if (r_col >= COL_W'(LINE_CELLS)) begin
            eff_col = '0;
            eff_row = adv_row;
        end else begin
            eff_col = r_col;
            eff_row = r_row;
        end
        put_ca = cell_address(8'(eff_col), eff_row);
        n_col  = r_col;
        n_row  = r_row;
        if (in_code == NEWLINE_CODE) begin
            n_col = '0;
            n_row = adv_row;
        end else begin
            n_row = eff_row;
            n_col = put_ca.ok ? eff_col + COL_W'(1) : eff_col;
        end
    end

    // Pending buffer write from put and set
    always_comb begin
        pwe    = 1'b0;
        pwaddr = set_ca.addr;
        if (in_accept) begin
            case (in_func)
                F_PUT: begin
                    pwe    = (in_code != NEWLINE_CODE) && put_ca.ok;
                    pwaddr = put_ca.addr;
                end
                F_SET: begin
                    pwe    = set_ca.ok;
                    pwaddr = set_ca.addr;
                end
                default: pwe = 1'b0;
            endcase
        end
    end

    // Compare unit: pending cells not yet written read as the fill value, shown ones as zero
    assign pend_val  = r_pvalid[r_idx] ? pend_rdata : r_fill;
    assign shown_val = r_svalid[r_idx] ? shown_rdata : 8'd0;
    assign at_last   = (r_idx == r_last_idx);
    assign seg_start = ADDR_W'(in_segment) * ADDR_W'(SEGMENT_SPAN);

    // Output staging: one byte held back so the final one can carry last
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign can_push  = !r_hold_v || out_free;
    assign push_req  = ((r_state == S_CMD) || (r_state == S_DATA)) && can_push;
    assign push_rs   = (r_state == S_DATA);
    assign remap     = (r_idx >= ADDR_W'(SECOND_BANK)) ? r_idx + ADDR_W'(BANK_REMAP) : r_idx;
    assign push_byte = push_rs ? r_cell : (CMD_SET_ADDRESS | 8'(remap));
    assign swe       = (r_state == S_DATA) && can_push;

    // Next scan index, also the read address of both buffers
    always_comb begin
        n_idx = r_idx;
        case (r_state)
            S_IDLE: begin
                if (in_accept && in_func == F_RENDER) begin
                    n_idx = seg_start;
                end
            end
            S_SCAN: begin
                if (pend_val == shown_val && !at_last) begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            S_DATA: begin
                if (can_push && !at_last) begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            default: n_idx = r_idx;
        endcase
    end

    clre_ram #(
        .WIDTH (8),
        .DEPTH (DISPLAY_CELLS)
    ) u_pending (
        .i_clk   (i_clk),
        .i_we    (pwe),
        .i_waddr (pwaddr),
        .i_wdata (in_code),
        .i_raddr (n_idx),
        .o_rdata (pend_rdata)
    );

    clre_ram #(
        .WIDTH (8),
        .DEPTH (DISPLAY_CELLS)
    ) u_shown (
        .i_clk   (i_clk),
        .i_we    (swe),
        .i_waddr (r_idx),
        .i_wdata (r_cell),
        .i_raddr (n_idx),
        .o_rdata (shown_rdata)
    );

    // Sequencer, buffer tags, cursor and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_blank     <= BLANK_RESET;
            r_fill      <= BLANK_RESET;
            r_pvalid    <= '0;
            r_svalid    <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_tracked   <= ADDR_UNKNOWN;
            r_idx       <= '0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;

            if (cfg_write) begin
                r_blank <= pwdata[7:0];
            end

            if (pwe) begin
                r_pvalid[pwaddr] <= 1'b1;
            end
            if (swe) begin
                r_svalid[r_idx] <= 1'b1;
            end

            // Output register and hold stage
            if (push_req) begin
                if (r_hold_v) begin
                    r_out_valid <= 1'b1;
                    r_out_rs    <= r_hold_rs;
                    r_out_byte  <= r_hold_byte;
                    r_out_last  <= 1'b0;
                end else if (i_m_axis_tready) begin
                    r_out_valid <= 1'b0;
                end
                r_hold_v    <= 1'b1;
                r_hold_rs   <= push_rs;
                r_hold_byte <= push_byte;
            end else if (r_state == S_FLUSH && r_hold_v && out_free) begin
                r_out_valid <= 1'b1;
                r_out_rs    <= r_hold_rs;
                r_out_byte  <= r_hold_byte;
                r_out_last  <= 1'b1;
                r_hold_v    <= 1'b0;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        case (in_func)
                            F_CLEAR: begin
                                r_fill   <= r_blank;
                                r_pvalid <= '0;
                                r_col    <= '0;
                                r_row    <= '0;
                            end
                            F_PUT: begin
                                r_col <= n_col;
                                r_row <= n_row;
                            end
                            F_RENDER: begin
                                r_last_idx <= seg_start + SPAN_LAST;
                                if (in_segment == 2'd0) begin
                                    r_tracked <= ADDR_UNKNOWN;
                                end
                                r_state <= S_SCAN;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (pend_val != shown_val) begin
                        r_cell  <= pend_val;
                        r_state <= (r_tracked != 8'(r_idx)) ? S_CMD : S_DATA;
                    end else if (at_last) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_CMD: begin
                    if (can_push) begin
                        r_tracked <= 8'(r_idx);
                        r_state   <= S_DATA;
                    end
                end
                S_DATA: begin
                    if (can_push) begin
                        r_tracked <= 8'(r_idx) + 8'd1;
                        r_state   <= at_last ? S_FLUSH : S_SCAN;
                    end
                end
                S_FLUSH: begin
                    if (!r_hold_v || out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = r_out_rs;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// File: sim/clre_checker.sv
`timescale 1ns / 100ps
// Checker for the character LCD refresh engine: watches the item, result and APB channels,
// keeps its own shadow buffers and compares every result byte. Depends on clre_pkg.
module clre_checker
    import clre_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire [23:0]  i_s_tdata,
    input  wire [1:0]   i_s_tuser,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire [7:0]   i_m_tdata,
    input  wire         i_m_tuser,
    input  wire         i_m_tlast,
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire [2:0]   i_paddr,
    input  wire [31:0]  i_pwdata,
    input  wire         i_pready,
    output int          o_fail_count,
    output int          o_outstanding
);

    localparam int ROW_CELLS = DEF_LINE_CELLS;
    localparam int ROW_COUNT = DEF_LINES;
    localparam logic [2:0] BLANK_CODE_ADDR = {REG_BLANK_CODE, 2'b00};

    typedef struct packed {
        logic       reg_select;
        logic [7:0] out_byte;
        logic       last;
    } t_panel_byte;

    // Shadow copy of the engine state
    logic [7:0]  blank_code;
    logic [7:0]  pending_cells [DISPLAY_CELLS];
    logic [7:0]  shown_cells [DISPLAY_CELLS];
    int          cursor_col;
    int          cursor_row;
    int          tracked_addr;
    t_panel_byte expected_bytes [$];

    // Display address of a cell, DISPLAY_CELLS when out of range
    function automatic int cell_addr(input int col, input int row);
        int base;
        if (col >= ROW_CELLS || row >= ROW_COUNT) return DISPLAY_CELLS;
        case (row)
            0:       base = 0;
            1:       base = SECOND_BANK;
            2:       base = ROW_CELLS;
            default: base = SECOND_BANK + ROW_CELLS;
        endcase
        if (base + col >= DISPLAY_CELLS) return DISPLAY_CELLS;
        return base + col;
    endfunction

    function automatic void next_row();
        cursor_col = 0;
        if (cursor_row < ROW_COUNT) cursor_row++;
    endfunction

    function automatic void reset_shadow();
        blank_code = BLANK_RESET;
        foreach (pending_cells[i]) pending_cells[i] = BLANK_RESET;
        foreach (shown_cells[i]) shown_cells[i] = 8'd0;
        cursor_col   = 0;
        cursor_row   = 0;
        tracked_addr = int'(ADDR_UNKNOWN);
        expected_bytes.delete();
    endfunction

    // Apply one accepted item to the shadow state, queue the bytes a render sends
    function automatic void update_shadow(input t_func func, input int col, input int row,
                                          input logic [7:0] code, input int seg);
        int          addr;
        int          first;
        int          sent;
        t_panel_byte pb;
        case (func)
            F_CLEAR: begin
                foreach (pending_cells[i]) pending_cells[i] = blank_code;
                cursor_col = 0;
                cursor_row = 0;
            end
            F_PUT: begin
                if (code == NEWLINE_CODE) begin
                    next_row();
                end else begin
                    if (cursor_col >= ROW_CELLS) next_row();
                    addr = cell_addr(cursor_col, cursor_row);
                    if (addr < DISPLAY_CELLS) begin
                        pending_cells[addr] = code;
                        cursor_col++;
                    end
                end
            end
            F_SET: begin
                addr = cell_addr(col, row);
                if (addr < DISPLAY_CELLS) pending_cells[addr] = code;
            end
            default: begin
                // segment 0 forgets where the panel's address counter is
                if (seg == 0) tracked_addr = int'(ADDR_UNKNOWN);
                first = seg * SEGMENT_SPAN;
                sent  = 0;
                for (int i = first; i < first + SEGMENT_SPAN && i < DISPLAY_CELLS; i++) begin
                    if (pending_cells[i] != shown_cells[i]) begin
                        if (tracked_addr != i) begin
                            pb.reg_select = 1'b0;
                            pb.out_byte   = CMD_SET_ADDRESS
                                          | 8'(i >= SECOND_BANK ? i + BANK_REMAP : i);
                            pb.last       = 1'b0;
                            expected_bytes.push_back(pb);
                            sent++;
                            tracked_addr = i;
                        end
                        pb.reg_select = 1'b1;
                        pb.out_byte   = pending_cells[i];
                        pb.last       = 1'b0;
                        expected_bytes.push_back(pb);
                        sent++;
                        shown_cells[i] = pending_cells[i];
                        tracked_addr   = (tracked_addr + 1) & 255;
                    end
                end
                if (sent > 0) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    // Compare result transactions, then predict from item and register transactions
    always @(posedge i_clk) begin
        t_panel_byte exp_b;
        if (!i_rst_n) begin
            reset_shadow();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected result: out_byte %0h reg_select %0d last %0d",
                           i_m_tdata, i_m_tuser, i_m_tlast);
                    o_fail_count++;
                end else begin
                    exp_b = expected_bytes.pop_front();
                    if (i_m_tuser !== exp_b.reg_select) begin
                        $error("reg_select: expected %0d, actual %0d",
                               exp_b.reg_select, i_m_tuser);
                        o_fail_count++;
                    end
                    if (i_m_tdata !== exp_b.out_byte) begin
                        $error("out_byte: expected %0h, actual %0h", exp_b.out_byte, i_m_tdata);
                        o_fail_count++;
                    end
                    if (i_m_tlast !== exp_b.last) begin
                        $error("last: expected %0d, actual %0d", exp_b.last, i_m_tlast);
                        o_fail_count++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == BLANK_CODE_ADDR)
                blank_code = i_pwdata[7:0];
            if (i_s_tvalid && i_s_tready)
                update_shadow(t_func'(i_s_tuser), int'(i_s_tdata[4:0]), int'(i_s_tdata[7:5]),
                              i_s_tdata[15:8], int'(i_s_tdata[17:16]));
        end
        o_outstanding = expected_bytes.size();
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Top of the refresh engine testbench: clock, reset, item and APB stimulus, verdict.
// Depends on clre_pkg, character_lcd_refresh_engine_core and clre_checker.
module testbench;
    import clre_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int RENDER_SETTLE  = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 20;
    localparam logic [2:0] BLANK_CODE_ADDR = {REG_BLANK_CODE, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int outstanding;
    int items_sent = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic holding = 1'b0;
    event start_hold;

    character_lcd_refresh_engine_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    clre_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk) cycle_count++;
        $display("Regression FAIL");
        $finish;
    end

    // Long receiver hold-off, timed in its own process
    initial begin
        @(start_hold);
        @(posedge i_clk);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding = 1'b0;
    end

    // Result side back-pressure
    initial begin
        forever begin
            @(negedge i_clk);
            m_tready <= !holding && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offer one item and hold it until the engine takes the transaction
    task automatic send_item(input t_func func, input logic [4:0] col, input logic [2:0] row,
                             input logic [7:0] code, input logic [1:0] seg);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, seg, code, row, col};
        s_tuser  <= func;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_random(input t_func func);
        send_item(func, 5'($urandom), 3'($urandom), 8'($urandom), 2'($urandom));
    endtask

    // Wait until every expected byte is out and any silent render has finished
    task automatic settle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (RENDER_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_blank(input logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BLANK_CODE_ADDR;
        pwdata  <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly text runs, cell writes and segment sweeps, with some clears and noise
    task automatic random_phase(input int target);
        int pick;
        int run_len;
        logic [7:0] ch;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_random(F_CLEAR);
            end else if (pick < 38) begin
                run_len = $urandom_range(1, 24);
                repeat (run_len) begin
                    ch = ($urandom_range(0, 9) == 0) ? NEWLINE_CODE : 8'($urandom);
                    send_item(F_PUT, 5'($urandom), 3'($urandom), ch, 2'($urandom));
                end
            end else if (pick < 60) begin
                send_item(F_SET, 5'($urandom_range(0, DEF_LINE_CELLS - 1)),
                          3'($urandom_range(0, DEF_LINES - 1)), 8'($urandom), 2'($urandom));
            end else if (pick < 68) begin
                send_random(F_SET);
            end else if (pick < 84) begin
                for (int s = 0; s < 4; s++)
                    send_item(F_RENDER, 5'($urandom), 3'($urandom), 8'($urandom), 2'(s));
            end else begin
                send_random(F_RENDER);
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        logic [7:0] blank_values [4];
        int idle_pct [4];
        int stall_pct [4];
        blank_values = '{8'h00, 8'hFF, 8'($urandom), BLANK_RESET};
        idle_pct     = '{0, 62, 0, 18};
        stall_pct    = '{0, 0, 62, 18};

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset contents against a zeroed panel, then edge cases
        for (int s = 0; s < 4; s++) send_item(F_RENDER, 5'd0, 3'd0, 8'd0, 2'(s));
        send_item(F_RENDER, 5'd31, 3'd7, 8'hFF, 2'd2);   // nothing changed
        send_item(F_CLEAR, 5'd0, 3'd0, 8'd0, 2'd0);
        send_item(F_PUT, 5'd0, 3'd0, 8'h48, 2'd0);
        send_item(F_PUT, 5'd0, 3'd0, NEWLINE_CODE, 2'd0);
        send_item(F_PUT, 5'd31, 3'd7, 8'h69, 2'd3);
        send_item(F_SET, 5'd19, 3'd3, 8'hFF, 2'd0);
        send_item(F_SET, 5'd0, 3'd0, 8'h00, 2'd3);
        send_item(F_SET, 5'd20, 3'd1, 8'h55, 2'd0);       // column off the line
        send_item(F_SET, 5'd31, 3'd7, 8'hAA, 2'd0);       // both off the panel
        send_item(F_SET, 5'd3, 3'd4, 8'h11, 2'd0);        // row off the panel
        repeat (4) send_item(F_PUT, 5'd0, 3'd0, NEWLINE_CODE, 2'd0);
        send_item(F_PUT, 5'd0, 3'd0, 8'h78, 2'd0);        // below the last line, dropped
        for (int s = 0; s < 4; s++) send_item(F_RENDER, 5'd0, 3'd0, 8'd0, 2'(s));
        send_item(F_RENDER, 5'd0, 3'd0, 8'd0, 2'd1);      // address carried on, no change
        settle();

        // Random phases, each under its own blank code and idling mix
        for (int ph = 0; ph < 4; ph++) begin
            write_blank(blank_values[ph]);
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            if (ph == 0) begin
                -> start_hold;
                send_item(F_CLEAR, 5'd0, 3'd0, 8'd0, 2'd0);
                for (int s = 0; s < 4; s++) send_random(F_RENDER);
            end
            random_phase(items_sent + PHASE_ITEMS);
            settle();
        end

        if (fail_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/clre_pkg.sv
rtl/clre_ram.sv
rtl/character_lcd_refresh_engine_core.sv
sim/clre_checker.sv
sim/testbench.sv
